/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Overlapping implication: cons must hold in the same cycle as ante.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Non-overlapping implication: cons must hold in the cycle after ante.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* sv/dvru_pkg.sv */
// ----------------------------------------------------------------------------
// dvru_pkg
// Types, codes and constants of the distance-vector route update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dvru_pkg;

	localparam int NODES     = 32;
	localparam int IDX_W     = $clog2(NODES);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	localparam logic [2:0] OP_ADV     = 3'd0;
	localparam logic [2:0] OP_END     = 3'd1;
	localparam logic [2:0] OP_EXPIRE  = 3'd2;
	localparam logic [2:0] OP_INSTALL = 3'd3;
	localparam logic [2:0] OP_LOOKUP  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_INFINITY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE = 1'd1;

	localparam logic [15:0] INFINITY_RESET = 16'd16;
	localparam logic [4:0]  OWN_NODE_RESET = 5'd0;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [4:0]  dst_node;
		logic [4:0]  neighbor;
		logic [15:0] adv_cost;
		logic [15:0] link_metric;
	} req_item_t;

	typedef struct packed {
		logic        changed;
		logic        found;
		logic [4:0]  next_hop;
		logic [15:0] route_cost_out;
	} resp_item_t;

	// Source of the table read address.
	typedef enum logic [1:0] {
		RD_REQ,
		RD_ITEM,
		RD_FIRST,
		RD_SCAN
	} rd_sel_t;

	typedef struct packed {
		rd_sel_t rd_sel;
		logic    load_item;
		logic    scan_start;
		logic    scan_step;
		logic    eval_fire;
		logic    fin_fire;
	} dvru_cmd_t;

	typedef struct packed {
		logic scan_op;
		logic scan_last;
	} dvru_status_t;

endpackage

`default_nettype wire

/* sv/dvru_dp.sv */
// ----------------------------------------------------------------------------
// dvru_dp
// Datapath: route table, seen flags, configuration and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire dvru_pkg::req_item_t               req_data,
	input  wire logic                              cfg_we,
	input  wire logic [dvru_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dvru_pkg::CFG_W-1:0]        cfg_data,
	input  wire dvru_pkg::dvru_cmd_t               cmd,
	output dvru_pkg::dvru_status_t                 status,
	output dvru_pkg::resp_item_t                   resp_data
);

	import dvru_pkg::*;

	localparam logic [5:0] NODE_LIM = 6'(NODES);

	logic [15:0]       infinity_q;
	logic [4:0]        own_node_q;
	logic [NODES-1:0]  valid_q;
	logic [NODES-1:0]  seen_q;
	logic [20:0]       mem [NODES];
	logic [20:0]       rd_q;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  cnt_q;
	logic              chg_q;
	req_item_t         item_q;
	resp_item_t        res_q;

	logic [15:0] rd_cost;
	logic [4:0]  rd_next;
	logic        dest_ok;
	logic        dest_valid;
	logic [16:0] path;
	logic        adv_take;
	logic        keep;
	logic        wr_en;
	logic [15:0] wr_cost;
	logic [5:0]  rank_old;
	logic [5:0]  rank_new;
	logic        purge;
	resp_item_t  eval_res;

	assign rd_cost = rd_q[20:5];
	assign rd_next = rd_q[4:0];

	function automatic logic [5:0] hop_rank(input logic [4:0] hop,
	                                        input logic [4:0] own);
		hop_rank = (hop == own) ? 6'd0 : {1'b0, hop} + 6'd1;
	endfunction

	always_comb begin
		unique case (cmd.rd_sel)
			RD_REQ:   rd_addr = req_data.dst_node;
			RD_ITEM:  rd_addr = item_q.dst_node;
			RD_FIRST: rd_addr = '0;
			RD_SCAN:  rd_addr = cnt_q + IDX_W'(1);
			default:  rd_addr = '0;
		endcase
	end

	assign status.scan_op   = (req_data.opcode == OP_END) ||
		(req_data.opcode == OP_EXPIRE);
	assign status.scan_last = (cnt_q == IDX_W'(NODES - 1));

	// Single-entry decision for entries, installs and lookups.
	always_comb begin
		dest_ok    = {1'b0, item_q.dst_node} < NODE_LIM;
		dest_valid = valid_q[item_q.dst_node];
		path       = {1'b0, item_q.adv_cost} + {1'b0, item_q.link_metric};
		adv_take   = dest_ok && (path < {1'b0, infinity_q});
		rank_old   = hop_rank(rd_next, own_node_q);
		rank_new   = hop_rank(item_q.neighbor, own_node_q);
		keep       = dest_valid &&
			(((rd_cost < path[15:0]) && (rd_next != item_q.neighbor)) ||
			((rd_cost == path[15:0]) && (rank_old <= rank_new)));
		wr_en      = 1'b0;
		wr_cost    = item_q.adv_cost;
		eval_res   = '0;
		unique case (item_q.opcode)
			OP_ADV: begin
				wr_en            = adv_take && !keep;
				wr_cost          = path[15:0];
				eval_res.changed = adv_take && !keep;
			end
			OP_INSTALL: begin
				wr_en            = dest_ok;
				eval_res.changed = dest_ok && (!dest_valid ||
					(rd_cost != item_q.adv_cost) || (rd_next != item_q.neighbor));
			end
			OP_LOOKUP: begin
				if (dest_ok && dest_valid) begin
					eval_res.found          = 1'b1;
					eval_res.next_hop       = rd_next;
					eval_res.route_cost_out = rd_cost;
				end
			end
			default: ;
		endcase
	end

	// A route via the neighbour is purged on expiry, or on end of round if unseen.
	assign purge = valid_q[cnt_q] && (rd_next == item_q.neighbor) &&
		((item_q.opcode == OP_EXPIRE) || !seen_q[cnt_q]);

	always_ff @(posedge clk) begin
		if (cmd.eval_fire && wr_en) begin
			mem[item_q.dst_node] <= {wr_cost, item_q.neighbor};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req_data;
		end
		if (cmd.eval_fire) begin
			res_q <= eval_res;
		end else if (cmd.fin_fire) begin
			res_q         <= '0;
			res_q.changed <= chg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infinity_q <= INFINITY_RESET;
			own_node_q <= OWN_NODE_RESET;
			valid_q    <= '0;
			seen_q     <= '0;
			cnt_q      <= '0;
			chg_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_INFINITY: infinity_q <= cfg_data[15:0];
					REG_OWN_NODE: own_node_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (cmd.scan_start) begin
				cnt_q <= '0;
				chg_q <= 1'b0;
			end else if (cmd.scan_step) begin
				cnt_q <= cnt_q + IDX_W'(1);
				if (purge) begin
					valid_q[cnt_q] <= 1'b0;
					chg_q          <= 1'b1;
				end
			end
			if (cmd.eval_fire) begin
				if (wr_en) begin
					valid_q[item_q.dst_node] <= 1'b1;
				end
				if ((item_q.opcode == OP_ADV) && adv_take) begin
					seen_q[item_q.dst_node] <= 1'b1;
				end
			end
			if (cmd.fin_fire && (item_q.opcode == OP_END)) begin
				seen_q <= '0;
			end
		end
	end

	assign resp_data = res_q;

endmodule

`default_nettype wire

/* sv/dvru_ctrl.sv */
// ----------------------------------------------------------------------------
// dvru_ctrl
// Controller: sequences one request at a time and owns the response valid.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_ready,
	output logic                        resp_valid,
	input  wire logic                   resp_ready,
	input  wire dvru_pkg::dvru_status_t status,
	output dvru_pkg::dvru_cmd_t         cmd
);

	import dvru_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       resp_valid_q;
	logic       slot_free;

	assign slot_free = !resp_valid_q || resp_ready;
	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.rd_sel = status.scan_op ? RD_FIRST : RD_REQ;
				if (req_valid) begin
					cmd.load_item  = 1'b1;
					cmd.scan_start = status.scan_op;
					state_d        = status.scan_op ? S_SCAN : S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.rd_sel = RD_ITEM;
				if (slot_free) begin
					cmd.eval_fire = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.rd_sel    = RD_SCAN;
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.rd_sel = RD_ITEM;
				if (slot_free) begin
					cmd.fin_fire = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			resp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.eval_fire || cmd.fin_fire) begin
				resp_valid_q <= 1'b1;
			end else if (resp_ready) begin
				resp_valid_q <= 1'b0;
			end
		end
	end

	assign resp_valid = resp_valid_q;

endmodule

`default_nettype wire

/* sv/distance_vector_route_update_unit.sv */
// ----------------------------------------------------------------------------
// distance_vector_route_update_unit
// Distance-vector route table with entry, purge, install and lookup requests.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready with a req_item_t payload; each gives
// exactly one response on resp_valid/resp_ready with a resp_item_t payload.
// Registers infinity_cost (index 0) and own_node (index 1) are written through
// cfg_we/cfg_index/cfg_data; the user must do so while no request is in
// flight, as the block does not enforce it. An advertised entry, install,
// lookup or unknown opcode first reads the route entry from the table
// memory, then decides and writes back; the response is registered. A new
// request is taken once the previous one has left its last step.
// End of advertisement and neighbour expiry walk the whole table through its
// single read port, one entry a cycle.
// Only one request is in work at a time; the next one is taken while the
// previous response still waits in the output register.
// If the receiver stalls, the finished response is held and the next request
// waits in its decision step until the output register frees.
// Reset empties the table, clears the seen flags and restores the registers
// to 16 and 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module distance_vector_route_update_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_ready,
	input  wire dvru_pkg::req_item_t               req_data,
	output logic                                   resp_valid,
	input  wire logic                              resp_ready,
	output dvru_pkg::resp_item_t                   resp_data,
	input  wire logic                              cfg_we,
	input  wire logic [dvru_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dvru_pkg::CFG_W-1:0]        cfg_data
);

	import dvru_pkg::*;

	dvru_cmd_t    cmd;
	dvru_status_t status;

	dvru_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.resp_valid (resp_valid),
		.resp_ready (resp_ready),
		.status     (status),
		.cmd        (cmd)
	);

	dvru_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.resp_data (resp_data)
	);

	// Only one request is in work at a time.
	`ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)
	// A response is only produced into a free output register.
	`ASSERT_IMP(a_slot_free, cmd.eval_fire || cmd.fin_fire, !resp_valid || resp_ready)
	// A table walk never overlaps request acceptance.
	`ASSERT_IMP(a_scan_busy, cmd.scan_step, !req_ready)
	// The last walked entry is followed by the response step.
	`ASSERT_NXT(a_scan_end, cmd.scan_step && status.scan_last, !cmd.scan_step)

endmodule

`default_nettype wire
